// ===== rtl/ptt_pkg.sv =====
// Package for the periodic task timer bank.
// Sizes, operation codes and the structs shared by the controller and top level.
// No dependencies.
package ptt_pkg;

    localparam int TASKS       = 16;
    localparam int SLOT_W      = 4;
    localparam int TIMER_W     = 32;
    localparam int COUNT_W     = 5;
    localparam int FUNC_W      = 4;
    localparam int IN_TDATA_W  = 40;
    localparam int OUT_FIELD_W = SLOT_W + 1 + 2 * TIMER_W + COUNT_W;
    localparam int OUT_TDATA_W = 80;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

    // operation codes carried in the input tuser
    localparam logic [FUNC_W-1:0] FN_TICK       = FUNC_W'(0);
    localparam logic [FUNC_W-1:0] FN_SERVICE    = FUNC_W'(1);
    localparam logic [FUNC_W-1:0] FN_SETUP_PER  = FUNC_W'(2);
    localparam logic [FUNC_W-1:0] FN_SETUP_ONCE = FUNC_W'(3);
    localparam logic [FUNC_W-1:0] FN_JOIN       = FUNC_W'(4);
    localparam logic [FUNC_W-1:0] FN_DROP       = FUNC_W'(5);
    localparam logic [FUNC_W-1:0] FN_SET_TIMER  = FUNC_W'(6);
    localparam logic [FUNC_W-1:0] FN_SET_PERIOD = FUNC_W'(7);
    localparam logic [FUNC_W-1:0] FN_QUERY      = FUNC_W'(8);

    typedef struct packed {
        logic               re;
        logic [SLOT_W-1:0]  raddr;
        logic               cd_we;
        logic               pd_we;
        logic [SLOT_W-1:0]  waddr;
        logic [TIMER_W-1:0] cd_wdata;
        logic [TIMER_W-1:0] pd_wdata;
    } t_mem_req;

    typedef struct packed {
        logic [SLOT_W-1:0]  task_index;
        logic               fired;
        logic               last;
        logic               is_joined;
        logic [TIMER_W-1:0] timer_value;
        logic [TIMER_W-1:0] period_value;
        logic [COUNT_W-1:0] joined_count;
    } t_result;

endpackage

// ===== rtl/ptt_ram.sv =====
// Simple dual-port synchronous RAM, one write and one registered read port.
// Generic; no package dependency.
module ptt_ram #(
    parameter int DATA_W = 32,
    parameter int ADDR_W = 4
) (
    input  logic              i_clk,
    input  logic              i_we,
    input  logic [ADDR_W-1:0] i_waddr,
    input  logic [DATA_W-1:0] i_wdata,
    input  logic              i_re,
    input  logic [ADDR_W-1:0] i_raddr,
    output logic [DATA_W-1:0] o_rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];
    logic [DATA_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/ptt_ctrl.sv =====
// Sequencer of the timer bank: slot flags, tick and service sweeps, single-slot ops.
// Depends on ptt_pkg; drives the countdown and period RAMs through t_mem_req.
module ptt_ctrl (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_ready,
    input  logic [ptt_pkg::FUNC_W-1:0]    i_func,
    input  logic [ptt_pkg::SLOT_W-1:0]    i_slot,
    input  logic [ptt_pkg::TIMER_W-1:0]   i_value,
    output ptt_pkg::t_mem_req             o_mem,
    input  logic [ptt_pkg::TIMER_W-1:0]   i_cd_rdata,
    input  logic [ptt_pkg::TIMER_W-1:0]   i_pd_rdata,
    output logic                          o_res_valid,
    input  logic                          i_res_ready,
    output ptt_pkg::t_result              o_res
);
    import ptt_pkg::*;

    typedef enum logic [2:0] {
        S_CLR, S_IDLE, S_OP, S_TICK, S_TICK_END, S_SVC, S_RD, S_EMIT
    } t_state;

    t_state               r_state, n_state;
    logic [FUNC_W-1:0]    r_func, n_func;
    logic [SLOT_W-1:0]    r_slot, n_slot;
    logic [TIMER_W-1:0]   r_value, n_value;
    logic [SLOT_W-1:0]    r_idx, n_idx;
    logic                 r_wb_valid, n_wb_valid;
    logic [SLOT_W-1:0]    r_wb_idx, n_wb_idx;
    logic [SLOT_W-1:0]    r_rep_idx, n_rep_idx;
    logic                 r_rep_fired, n_rep_fired;
    logic                 r_rep_last, n_rep_last;
    logic [TASKS-1:0]     r_once, n_once;
    logic [TASKS-1:0]     r_joined, n_joined;
    logic [TASKS-1:0]     r_pending, n_pending;
    logic [TASKS-1:0]     r_listed, n_listed;
    logic [COUNT_W-1:0]   r_active, n_active;

    logic [TIMER_W-1:0]   cd_dec;
    logic [TASKS-1:0]     cand;
    logic [TASKS-1:0]     later;
    logic [TASKS-1:0]     stale;

    assign o_in_ready = (r_state == S_IDLE);
    assign cd_dec     = i_cd_rdata - TIMER_W'(1);
    assign cand       = r_listed & r_joined & r_pending;
    assign later      = (cand >> r_idx) >> 1;
    assign stale      = r_listed & ~r_joined & ({TASKS{1'b1}} << r_idx);

    always_comb begin
        n_state     = r_state;
        n_func      = r_func;
        n_slot      = r_slot;
        n_value     = r_value;
        n_idx       = r_idx;
        n_wb_valid  = r_wb_valid;
        n_wb_idx    = r_wb_idx;
        n_rep_idx   = r_rep_idx;
        n_rep_fired = r_rep_fired;
        n_rep_last  = r_rep_last;
        n_once      = r_once;
        n_joined    = r_joined;
        n_pending   = r_pending;
        n_listed    = r_listed;
        n_active    = r_active;
        o_mem       = '0;
        o_res_valid = 1'b0;

        // tick writeback of the slot read in the previous cycle
        if ((r_state == S_TICK || r_state == S_TICK_END) && r_wb_valid) begin
            if (r_listed[r_wb_idx] && (i_cd_rdata != '0)) begin
                o_mem.cd_we = 1'b1;
                o_mem.waddr = r_wb_idx;
                if (cd_dec == '0) begin
                    o_mem.cd_wdata      = i_pd_rdata;
                    n_pending[r_wb_idx] = 1'b1;
                end else begin
                    o_mem.cd_wdata = cd_dec;
                end
            end
        end

        case (r_state)
            S_CLR: begin
                // zero both stores one slot per cycle after reset
                o_mem.cd_we = 1'b1;
                o_mem.pd_we = 1'b1;
                o_mem.waddr = r_idx;
                if (r_idx == SLOT_W'(TASKS - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    n_func     = i_func;
                    n_slot     = i_slot;
                    n_value    = i_value;
                    n_idx      = '0;
                    n_wb_valid = 1'b0;
                    case (i_func)
                        FN_TICK:    n_state = S_TICK;
                        FN_SERVICE: n_state = S_SVC;
                        default:    n_state = S_OP;
                    endcase
                end
            end
            S_OP: begin
                case (r_func)
                    FN_SETUP_PER, FN_SETUP_ONCE: begin
                        if (r_joined[r_slot]) begin
                            n_active = r_active - COUNT_W'(1);
                        end
                        n_joined[r_slot]  = 1'b0;
                        n_pending[r_slot] = 1'b0;
                        n_listed[r_slot]  = 1'b0;
                        n_once[r_slot]    = (r_func == FN_SETUP_ONCE);
                        o_mem.cd_we       = 1'b1;
                        o_mem.pd_we       = 1'b1;
                        o_mem.waddr       = r_slot;
                        o_mem.cd_wdata    = r_value;
                        o_mem.pd_wdata    = r_value;
                    end
                    FN_JOIN: begin
                        if (!r_joined[r_slot]) begin
                            n_joined[r_slot] = 1'b1;
                            n_listed[r_slot] = 1'b1;
                            n_active         = r_active + COUNT_W'(1);
                        end
                    end
                    FN_DROP: begin
                        if (r_joined[r_slot]) begin
                            n_joined[r_slot]  = 1'b0;
                            n_pending[r_slot] = 1'b0;
                            n_active          = r_active - COUNT_W'(1);
                        end
                    end
                    FN_SET_TIMER: begin
                        o_mem.cd_we    = 1'b1;
                        o_mem.waddr    = r_slot;
                        o_mem.cd_wdata = r_value;
                    end
                    FN_SET_PERIOD: begin
                        o_mem.pd_we    = 1'b1;
                        o_mem.waddr    = r_slot;
                        o_mem.pd_wdata = r_value;
                    end
                    default: begin
                    end
                endcase
                n_state = S_RD;
            end
            S_TICK: begin
                o_mem.re   = 1'b1;
                o_mem.raddr = r_idx;
                n_wb_valid = 1'b1;
                n_wb_idx   = r_idx;
                if (r_idx == SLOT_W'(TASKS - 1)) begin
                    n_state = S_TICK_END;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_TICK_END: begin
                n_wb_valid = 1'b0;
                n_state    = S_RD;
            end
            S_SVC: begin
                // unlist every unjoined slot from here up; the pass may end early
                n_listed = r_listed & ~stale;
                if (cand[r_idx]) begin
                    n_pending[r_idx] = 1'b0;
                    if (r_once[r_idx]) begin
                        n_joined[r_idx] = 1'b0;
                        n_active        = r_active - COUNT_W'(1);
                    end
                    o_mem.re    = 1'b1;
                    o_mem.raddr = r_idx;
                    n_rep_idx   = r_idx;
                    n_rep_fired = 1'b1;
                    n_rep_last  = (later == '0);
                    n_state     = S_EMIT;
                end else if (r_idx == SLOT_W'(TASKS - 1)) begin
                    // nothing fired: report the addressed slot
                    n_state = S_RD;
                end else begin
                    n_idx = r_idx + SLOT_W'(1);
                end
            end
            S_RD: begin
                o_mem.re    = 1'b1;
                o_mem.raddr = r_slot;
                n_rep_idx   = r_slot;
                n_rep_fired = 1'b0;
                n_rep_last  = 1'b1;
                n_state     = S_EMIT;
            end
            S_EMIT: begin
                o_res_valid = 1'b1;
                if (i_res_ready) begin
                    if (r_rep_last) begin
                        n_state = S_IDLE;
                    end else begin
                        n_idx   = r_idx + SLOT_W'(1);
                        n_state = S_SVC;
                    end
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_res.task_index   = r_rep_idx;
        o_res.fired        = r_rep_fired;
        o_res.last         = r_rep_last;
        o_res.is_joined    = r_joined[r_rep_idx];
        o_res.timer_value  = i_cd_rdata;
        o_res.period_value = i_pd_rdata;
        o_res.joined_count = r_active;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_CLR;
            r_idx      <= '0;
            r_wb_valid <= 1'b0;
            r_once     <= '0;
            r_joined   <= '0;
            r_pending  <= '0;
            r_listed   <= '0;
            r_active   <= '0;
        end else begin
            r_state    <= n_state;
            r_idx      <= n_idx;
            r_wb_valid <= n_wb_valid;
            r_once     <= n_once;
            r_joined   <= n_joined;
            r_pending  <= n_pending;
            r_listed   <= n_listed;
            r_active   <= n_active;
        end
        r_func      <= n_func;
        r_slot      <= n_slot;
        r_value     <= n_value;
        r_wb_idx    <= n_wb_idx;
        r_rep_idx   <= n_rep_idx;
        r_rep_fired <= n_rep_fired;
        r_rep_last  <= n_rep_last;
    end

endmodule

// ===== rtl/periodic_task_timer_bank.sv =====
// Top level of the periodic task timer bank.
// Depends on ptt_pkg, ptt_ram (countdown and period stores) and ptt_ctrl.
//
//  Channel   Dir  Handshake                     Contents
//  s_axis    in   s_axis_tvalid/s_axis_tready   tuser: func; tdata: slot, value
//  m_axis    out  m_axis_tvalid/m_axis_tready   tuser: fired; tlast: last;
//                                               tdata: index, joined, timer, period, count
//
// Sequence: set/join/drop/query items pass the op, read and emit states; a tick reads
// one slot per cycle through the countdown RAM read port, writing back the slot read
// before it, then does the final read; a service visits the flags up to the last fired
// slot with one RAM read and result per fired slot, else every flag and the final read.
// Reset: synchronous, active low; clears all slot flags and the joined count, then
// a pass zeroes the countdown and period RAMs while s_axis_tready is low.
// Stalls: one output register decouples m_axis; the sequencer holds a result
// while the register is full and not drained, and takes a new item once idle.
module periodic_task_timer_bank (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    output logic                             s_axis_tready,
    input  logic [ptt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,  // [3:0] slot, [35:4] value
    input  logic [ptt_pkg::FUNC_W-1:0]       s_axis_tuser,  // [3:0] func
    output logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    output logic [ptt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,  // [3:0] task_index, [4] is_joined,
                                                            // [36:5] timer_value,
                                                            // [68:37] period_value,
                                                            // [73:69] joined_count
    output logic                             m_axis_tuser,  // [0] fired
    output logic                             m_axis_tlast
);
    import ptt_pkg::*;

    t_mem_req            w_mem;
    logic [TIMER_W-1:0]  w_cd_rdata;
    logic [TIMER_W-1:0]  w_pd_rdata;
    logic                w_res_valid;
    logic                w_res_ready;
    t_result             w_res;

    logic                r_out_valid;
    t_result             r_out;

    // countdown store: written by ticks, setups, set timer and the reset clear
    ptt_ram #(.DATA_W(TIMER_W), .ADDR_W(SLOT_W)) u_cd_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.cd_we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.cd_wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_cd_rdata)
    );

    // period store: written by setups, set period and the reset clear, read for reloads
    ptt_ram #(.DATA_W(TIMER_W), .ADDR_W(SLOT_W)) u_pd_ram (
        .i_clk   (i_clk),
        .i_we    (w_mem.pd_we),
        .i_waddr (w_mem.waddr),
        .i_wdata (w_mem.pd_wdata),
        .i_re    (w_mem.re),
        .i_raddr (w_mem.raddr),
        .o_rdata (w_pd_rdata)
    );

    ptt_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_func      (s_axis_tuser),
        .i_slot      (s_axis_tdata[SLOT_W-1:0]),
        .i_value     (s_axis_tdata[SLOT_W +: TIMER_W]),
        .o_mem       (w_mem),
        .i_cd_rdata  (w_cd_rdata),
        .i_pd_rdata  (w_pd_rdata),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res)
    );

    // load the output register when empty or being drained this cycle
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_out.fired;
    assign m_axis_tlast  = r_out.last;
    assign m_axis_tdata  = {{OUT_PAD_W{1'b0}}, r_out.joined_count, r_out.period_value,
                            r_out.timer_value, r_out.is_joined, r_out.task_index};

endmodule

// ===== rtl/ptt_checker.sv =====
// Port-level checks for the periodic task timer bank, bound to the top level.
// Depends on ptt_pkg for field widths and the slot count.
module ptt_checker (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             s_axis_tvalid,
    input  logic                             s_axis_tready,
    input  logic [ptt_pkg::IN_TDATA_W-1:0]   s_axis_tdata,
    input  logic [ptt_pkg::FUNC_W-1:0]       s_axis_tuser,
    input  logic                             m_axis_tvalid,
    input  logic                             m_axis_tready,
    input  logic [ptt_pkg::OUT_TDATA_W-1:0]  m_axis_tdata,
    input  logic                             m_axis_tuser,
    input  logic                             m_axis_tlast
);
    import ptt_pkg::*;

    logic [COUNT_W-1:0] joined_count;
    assign joined_count = m_axis_tdata[OUT_FIELD_W-1 -: COUNT_W];

    // output register empties on reset
    a_rst_empty: assert property (@(posedge i_clk) !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid after reset");

    // a stalled result holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled result changed");

    // the block works on one item at a time
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("item accepted while busy");

    // a result that reports no fired slot ends its item
    a_plain_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tuser |-> m_axis_tlast)
        else $error("non-fired result without last");

    // joined count never exceeds the slot count
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> joined_count <= COUNT_W'(TASKS))
        else $error("joined count out of range");

endmodule

bind periodic_task_timer_bank ptt_checker u_ptt_checker (.*);
